@@ design/ilstk_pkg.sv @@
// ----------------------------------------------------------------------------
// ilstk_pkg
// Shared constants, codes and types for the indexed LIFO stack core.
// ----------------------------------------------------------------------------
package ilstk_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNDER  = 2'd1,
    ST_OVER   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic                valid;
    logic [VALUE_W-1:0]  value;
    logic                empty;
    logic [COUNT_W-1:0]  count;
    status_t             status;
  } res_t;

endpackage

@@ design/ilstk_req_if.sv @@
// ----------------------------------------------------------------------------
// ilstk_req_if
// Request channel: operation, value and position with valid/ready.
// ----------------------------------------------------------------------------
interface ilstk_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       op;
  logic signed [ilstk_pkg::VALUE_W-1:0] value_in;
  logic [ilstk_pkg::POS_W-1:0]      position;

  modport source (output valid, op, value_in, position, input ready);
  modport sink   (input valid, op, value_in, position, output ready);
endinterface

@@ design/ilstk_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ilstk_rsp_if
// Result channel: removed value, empty flag, entry count and status.
// ----------------------------------------------------------------------------
interface ilstk_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ilstk_pkg::VALUE_W-1:0] value_out;
  logic                                 is_empty;
  logic [ilstk_pkg::COUNT_W-1:0]        entry_count;
  logic [1:0]                           status;

  modport source (output valid, value_out, is_empty, entry_count, status, input ready);
  modport sink   (input valid, value_out, is_empty, entry_count, status, output ready);
endinterface

@@ design/ilstk_ram.sv @@
// ----------------------------------------------------------------------------
// ilstk_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ilstk_ram #(
  parameter int WIDTH   = 32,
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/ilstk_ctrl.sv @@
// ----------------------------------------------------------------------------
// ilstk_ctrl
// Request sequencer: checks each request, then walks the entry RAM one
// read and one write per cycle to shift entries for insert and remove.
// ----------------------------------------------------------------------------
module ilstk_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  ilstk_req_if.sink              req,
  output ilstk_pkg::res_t        res,
  input  logic                   res_ready
);
  import ilstk_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_POP       = 7'b0000010,
    S_INS       = 7'b0000100,
    S_INS_LAST  = 7'b0001000,
    S_REM_FIRST = 7'b0010000,
    S_REM_SHIFT = 7'b0100000,
    S_FIN       = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0]    cur_r, cur_nxt;
  logic [ADDR_W-1:0]    last_r, last_nxt;
  logic [WORD_BITS-1:0] val_r, val_nxt;
  logic [VALUE_W-1:0]   res_value_r, res_value_nxt;
  status_t              res_status_r, res_status_nxt;

  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data;

  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     count_ext;
  logic                 full;
  logic                 none;

  ilstk_ram #(
    .WIDTH   (WORD_BITS),
    .ENTRIES (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pos_ext   = CMP_W'(req.position);
  assign count_ext = CMP_W'(count_r);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign none      = (count_r == '0);
  assign req.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    last_nxt       = last_r;
    val_nxt        = val_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = val_r;
    rd_en          = 1'b0;
    rd_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (req.valid) begin
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          val_nxt        = WORD_BITS'($unsigned(req.value_in));
          state_nxt      = S_FIN;
          unique case (op_t'(req.op))
            OP_PUSH: begin
              if (full) begin
                res_status_nxt = ST_OVER;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = ADDR_W'(count_r);
                wr_data   = WORD_BITS'($unsigned(req.value_in));
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (pos_ext > count_ext) begin
                res_status_nxt = ST_BADPOS;
              end else if (full) begin
                res_status_nxt = ST_OVER;
              end else if (pos_ext == '0) begin
                wr_en     = 1'b1;
                wr_addr   = ADDR_W'(count_r);
                wr_data   = WORD_BITS'($unsigned(req.value_in));
                count_nxt = count_r + CNT_W'(1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(count_r - CNT_W'(1));
                cur_nxt   = ADDR_W'(count_r - CNT_W'(1));
                last_nxt  = ADDR_W'(count_ext - pos_ext);
                count_nxt = count_r + CNT_W'(1);
                state_nxt = S_INS;
              end
            end
            OP_POP: begin
              if (none) begin
                res_status_nxt = ST_UNDER;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(count_r - CNT_W'(1));
                count_nxt = count_r - CNT_W'(1);
                state_nxt = S_POP;
              end
            end
            OP_REMOVE: begin
              if (none) begin
                res_status_nxt = ST_UNDER;
              end else if (pos_ext >= count_ext) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(req.position);
                cur_nxt   = ADDR_W'(req.position);
                last_nxt  = ADDR_W'(count_r - CNT_W'(1));
                count_nxt = count_r - CNT_W'(1);
                state_nxt = S_REM_FIRST;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_POP: begin
        res_value_nxt = VALUE_W'(rd_data);
        state_nxt     = S_FIN;
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = cur_r + ADDR_W'(1);
        wr_data = rd_data;
        if (cur_r == last_r) begin
          state_nxt = S_INS_LAST;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_r - ADDR_W'(1);
          cur_nxt = cur_r - ADDR_W'(1);
        end
      end
      S_INS_LAST: begin
        wr_en     = 1'b1;
        wr_addr   = last_r;
        wr_data   = val_r;
        state_nxt = S_FIN;
      end
      S_REM_FIRST: begin
        res_value_nxt = VALUE_W'(rd_data);
        if (cur_r == last_r) begin
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = cur_r + ADDR_W'(1);
          cur_nxt   = cur_r + ADDR_W'(1);
          state_nxt = S_REM_SHIFT;
        end
      end
      S_REM_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = cur_r - ADDR_W'(1);
        wr_data = rd_data;
        if (cur_r == last_r) begin
          state_nxt = S_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_r + ADDR_W'(1);
          cur_nxt = cur_r + ADDR_W'(1);
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    last_r       <= last_nxt;
    val_r        <= val_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
  end

  assign res.valid  = (state_r == S_FIN);
  assign res.value  = res_value_r;
  assign res.empty  = (count_r == '0);
  assign res.count  = COUNT_W'(count_r);
  assign res.status = res_status_r;

  // The entry count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds capacity");

  // An accepted transaction always leaves the idle state.
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid && req.ready |=> state_r != S_IDLE)
    else $error("accepted transaction did not start");

  // A delivered result returns the sequencer to idle.
  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && res_ready |=> state_r == S_IDLE)
    else $error("sequencer stuck after result");

  // The count only moves when a transaction is accepted.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.valid && req.ready) |=> $stable(count_r))
    else $error("entry count changed without a transaction");

  // The shift walk never reads the entry it writes in the same cycle.
  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("read and write collide on one entry");

endmodule

@@ design/indexed_lifo_stack_core.sv @@
// ----------------------------------------------------------------------------
// indexed_lifo_stack_core
// Bounded stack of signed words with push, insert at depth, pop and
// remove at position, backed by a single entry RAM.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_req   sink       op, value_in, position
//  out_rsp  source     value_out, is_empty, entry_count, status
//
//  A request is taken only when the sequencer is idle. Insert at depth d > 0
//  and remove at position p move the entries between that point and the top
//  by one RAM read and one write per cycle. A result sits in an output
//  register so the next request can be taken while it waits. Reset empties
//  the stack; the RAM is not cleared.
// ----------------------------------------------------------------------------
module indexed_lifo_stack_core (
  input  logic          clk,
  input  logic          rst_n,
  ilstk_req_if.sink     in_req,
  ilstk_rsp_if.source   out_rsp
);
  import ilstk_pkg::*;

  res_t                 res;
  logic                 res_ready;
  logic                 out_valid_r;
  logic [VALUE_W-1:0]   out_value_r;
  logic                 out_empty_r;
  logic [COUNT_W-1:0]   out_count_r;
  status_t              out_status_r;

  ilstk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_req),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_value_r  <= res.value;
      out_empty_r  <= res.empty;
      out_count_r  <= res.count;
      out_status_r <= res.status;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.value_out   = $signed(out_value_r);
  assign out_rsp.is_empty    = out_empty_r;
  assign out_rsp.entry_count = out_count_r;
  assign out_rsp.status      = out_status_r;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed LIFO stack core. A shadow copy of the
// stack predicts the value, empty flag, count and status of every request.
// Directed requests hit underflow, bad position and edge positions. Random
// traffic alternates between filling and draining phases so the stack
// reaches both full and empty many times. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ilstk_pkg::*;

  localparam int RANDOM_REQUESTS = 1300;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               empty;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } outcome_t;

  class stack_shadow;
    logic [VALUE_W-1:0] words [DEPTH];
    int                 fill;
    outcome_t           pending_outcomes [$];
    int                 mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int entry_total();
      return fill;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function void apply_request(op_t op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
      outcome_t o;
      int       slot;
      o.value  = '0;
      o.status = ST_OK;
      case (op)
        OP_PUSH: begin
          if (fill >= DEPTH) begin
            o.status = ST_OVER;
          end else begin
            words[fill] = val;
            fill++;
          end
        end
        OP_INSERT: begin
          if (int'(pos) > fill) begin
            o.status = ST_BADPOS;
          end else if (fill >= DEPTH) begin
            o.status = ST_OVER;
          end else begin
            slot = fill - int'(pos);
            for (int i = fill; i > slot; i--) words[i] = words[i-1];
            words[slot] = val;
            fill++;
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            o.status = ST_UNDER;
          end else begin
            fill--;
            o.value = words[fill];
          end
        end
        default: begin
          if (fill == 0) begin
            o.status = ST_UNDER;
          end else if (int'(pos) >= fill) begin
            o.status = ST_BADPOS;
          end else begin
            o.value = words[int'(pos)];
            for (int i = int'(pos); i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
      endcase
      o.empty = (fill == 0);
      o.count = fill[COUNT_W-1:0];
      pending_outcomes.push_back(o);
    endfunction

    function void check_result(logic [VALUE_W-1:0] value, logic empty,
                               logic [COUNT_W-1:0] count, logic [1:0] status);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result value=%h empty=%b count=%0d status=%0d",
                   $realtime, value, empty, count, status);
        mismatches++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (value !== want.value || empty !== want.empty || count !== want.count ||
          status !== want.status) begin
        if (mismatches < 10) begin
          $display("%0t: mismatch expected value=%h empty=%b count=%0d status=%0d",
                   $realtime, want.value, want.empty, want.count, want.status);
          $display("%0t: mismatch got      value=%h empty=%b count=%0d status=%0d",
                   $realtime, value, empty, count, status);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ilstk_req_if req_ch ();
  ilstk_rsp_if rsp_ch ();

  indexed_lifo_stack_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  stack_shadow stack = new();
  int          send_burst = 0;
  int          recv_burst = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly random waits, with occasional runs of back-to-back transactions.
  function automatic int draw_wait(ref int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(op_t op, logic [VALUE_W-1:0] val, logic [POS_W-1:0] pos);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.value_in <= val;
    req_ch.position <= pos;
    do @(posedge clk); while (!req_ch.ready);
    stack.apply_request(op, val, pos);
  endtask

  initial begin : drive_requests
    bit          filling;
    op_t         op;
    logic [4:0]  pos;
    int          cnt;
    rst_n           <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.op       <= OP_PUSH;
    req_ch.value_in <= '0;
    req_ch.position <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_request(OP_POP,    $urandom, 5'd31);
    send_request(OP_REMOVE, $urandom, 5'd0);
    send_request(OP_INSERT, $urandom, 5'd1);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 5'd0);
    send_request(OP_PUSH,   32'h8000_0000, 5'd31);
    send_request(OP_PUSH,   32'h0000_0000, 5'd0);
    send_request(OP_PUSH,   32'hFFFF_FFFF, 5'd16);
    send_request(OP_INSERT, 32'h5555_5555, 5'd4);
    send_request(OP_INSERT, 32'hAAAA_AAAA, 5'd2);
    send_request(OP_INSERT, $urandom, 5'd31);
    send_request(OP_INSERT, $urandom, 5'd7);
    send_request(OP_REMOVE, $urandom, 5'd6);
    send_request(OP_REMOVE, $urandom, 5'd31);
    send_request(OP_REMOVE, $urandom, 5'd0);
    send_request(OP_REMOVE, $urandom, 5'd4);
    send_request(OP_POP,    $urandom, 5'd31);
    send_request(OP_REMOVE, $urandom, 5'd1);
    send_request(OP_POP,    $urandom, 5'd0);
    send_request(OP_POP,    $urandom, 5'd16);

    filling = 1'b1;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      cnt = stack.entry_total();
      if (filling && cnt == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (!filling && cnt == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      else if ($urandom_range(0, 49) == 0) filling = ~filling;

      if ($urandom_range(0, 99) < 70 == filling) op = op_t'($urandom_range(0, 1));
      else op = op_t'($urandom_range(2, 3));

      if ($urandom_range(0, 99) < 12) begin
        op  = op_t'($urandom_range(0, 3));
        pos = POS_W'($urandom_range(0, 31));
      end else if (op == OP_INSERT) begin
        pos = POS_W'($urandom_range(0, cnt));
      end else if (op == OP_REMOVE && cnt > 0) begin
        pos = POS_W'($urandom_range(0, cnt - 1));
      end else begin
        pos = POS_W'($urandom_range(0, 31));
      end
      send_request(op, pick_word(), pos);
    end
    req_ch.valid <= 1'b0;

    while (stack.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (stack.mismatches == 0 && stack.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : take_results
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      stack.check_result(rsp_ch.value_out, rsp_ch.is_empty, rsp_ch.entry_count,
                         rsp_ch.status);
    end
  end

  initial begin : watchdog
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
design/ilstk_pkg.sv
design/ilstk_req_if.sv
design/ilstk_rsp_if.sv
design/ilstk_ram.sv
design/ilstk_ctrl.sv
design/indexed_lifo_stack_core.sv
tb/tb_top.sv
